// ===== sv/button_gesture_recognizer_unit_defines.svh =====
// Assertion macros shared by the button gesture recognizer RTL.
`ifndef BUTTON_GESTURE_RECOGNIZER_UNIT_DEFINES_SVH
`define BUTTON_GESTURE_RECOGNIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BGR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bgr assertion failed");

// Next-cycle implication, disabled during reset.
`define BGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bgr assertion failed");

`endif

// ===== sv/bgr_pkg.sv =====
// Types, codes and reset values of the button gesture recognizer.
package bgr_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned OpW     = 2;
    localparam int unsigned ActionW = 3;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [CfgW-1:0] DebounceReset    = 16'd30;
    localparam logic [CfgW-1:0] DoubleClickReset = 16'd350;
    localparam logic [CfgW-1:0] HoldReset        = 16'd500;

    typedef enum logic [OpW-1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2
    } t_op;

    typedef enum logic [ActionW-1:0] {
        ACT_NONE     = 3'd0,
        ACT_WAKE     = 3'd1,
        ACT_PRE_BEG  = 3'd2,
        ACT_PRE_DISC = 3'd3,
        ACT_ESCAPE   = 3'd4,
        ACT_PTT_BEG  = 3'd5,
        ACT_PTT_END  = 3'd6,
        ACT_ENTER    = 3'd7
    } t_action;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEBOUNCE     = 2'd0,
        CFG_DOUBLE_CLICK = 2'd1,
        CFG_HOLD         = 2'd2
    } t_cfg_idx;

endpackage

// ===== sv/bgr_if.sv =====
// Valid/ready channel interfaces for button events and gesture actions.
interface bgr_in_if;
    logic                        valid;
    logic                        ready;
    logic [bgr_pkg::OpW-1:0]     operation;
    logic [bgr_pkg::TimeW-1:0]   now_ms;
    logic                        display_on;
    logic                        view_open;
    logic                        sess_picked;
    logic                        input_locked;

    modport source (
        output valid, operation, now_ms, display_on, view_open,
               sess_picked, input_locked,
        input  ready
    );
    modport sink (
        input  valid, operation, now_ms, display_on, view_open,
               sess_picked, input_locked,
        output ready
    );
endinterface

interface bgr_out_if;
    logic                          valid;
    logic                          ready;
    logic [bgr_pkg::ActionW-1:0]   action;

    modport source (output valid, action, input ready);
    modport sink (input valid, action, output ready);
endinterface

// ===== sv/button_gesture_recognizer_unit.sv =====
// Button gesture recognizer: debounce, click, double click and hold detection.
//
// i_evt carries one event per transfer: press edge, release edge or time tick,
// with a millisecond timestamp and four context flags. o_act returns exactly
// one action code per event, in order. The three timing registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user is to write them only
// while the block is idle, which the block itself does not enforce. An index
// past the last register is ignored. An accepted event lands in an input register;
// when the result register is free or being read, the gesture logic (a few 32-bit
// subtract/compare paths) updates the state and loads the result register.
// Throughput is one event per cycle while o_act is not stalled; each event sees the
// state left by the one before it, since state and result register update at the same edge.
// When the receiver stalls, the result holds and the input register can
// still take one more event; i_evt.ready drops only when both are full.
// Synchronous reset empties both registers, restores the timing registers to
// 30, 350 and 500 ms and clears all gesture state.
`include "button_gesture_recognizer_unit_defines.svh"

module button_gesture_recognizer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bgr_in_if.sink                         i_evt,
    bgr_out_if.source                      o_act,
    input  logic                           i_cfg_we,
    input  logic [bgr_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [bgr_pkg::CfgW-1:0]       i_cfg_data
);

    logic [bgr_pkg::CfgW-1:0]  r_debounce;
    logic [bgr_pkg::CfgW-1:0]  r_dbl_window;
    logic [bgr_pkg::CfgW-1:0]  r_hold;

    logic                       r_in_valid;
    logic [bgr_pkg::OpW-1:0]    r_in_op;
    logic [bgr_pkg::TimeW-1:0]  r_in_now;
    logic                       r_in_scr;
    logic                       r_in_ok;

    logic                       r_out_valid;
    logic [bgr_pkg::ActionW-1:0] r_out_action;

    logic                       r_edge_seen;
    logic [bgr_pkg::TimeW-1:0]  r_last_edge_time;
    logic                       r_pressed;
    logic [bgr_pkg::TimeW-1:0]  r_press_start;
    logic                       r_swallow;
    logic                       r_awaiting;
    logic                       r_second_press;
    logic [bgr_pkg::TimeW-1:0]  r_first_release;
    logic                       r_talk;

    logic                       n_edge_seen;
    logic [bgr_pkg::TimeW-1:0]  n_last_edge_time;
    logic                       n_pressed;
    logic [bgr_pkg::TimeW-1:0]  n_press_start;
    logic                       n_swallow;
    logic                       n_awaiting;
    logic                       n_second_press;
    logic [bgr_pkg::TimeW-1:0]  n_first_release;
    logic                       n_talk;
    bgr_pkg::t_action           n_action;

    logic                       in_xfer;
    logic                       advance;
    logic [bgr_pkg::TimeW-1:0]  dt_edge;
    logic [bgr_pkg::TimeW-1:0]  dt_press;
    logic [bgr_pkg::TimeW-1:0]  dt_release;
    logic                       edge_dropped;
    logic                       in_dbl_window;
    logic                       hold_reached;
    logic                       dbl_expired;

    assign advance     = r_in_valid && (!r_out_valid || o_act.ready);
    assign i_evt.ready = !r_in_valid || advance;
    assign in_xfer     = i_evt.valid && i_evt.ready;

    assign o_act.valid  = r_out_valid;
    assign o_act.action = r_out_action;

    assign dt_edge       = r_in_now - r_last_edge_time;
    assign dt_press      = r_in_now - r_press_start;
    assign dt_release    = r_in_now - r_first_release;
    assign edge_dropped  = r_edge_seen &&
                           (dt_edge < {{(bgr_pkg::TimeW-bgr_pkg::CfgW){1'b0}}, r_debounce});
    assign in_dbl_window = dt_release <=
                           {{(bgr_pkg::TimeW-bgr_pkg::CfgW){1'b0}}, r_dbl_window};
    assign dbl_expired   = dt_release >=
                           {{(bgr_pkg::TimeW-bgr_pkg::CfgW){1'b0}}, r_dbl_window};
    assign hold_reached  = dt_press >=
                           {{(bgr_pkg::TimeW-bgr_pkg::CfgW){1'b0}}, r_hold};

    always_comb begin
        n_edge_seen      = r_edge_seen;
        n_last_edge_time = r_last_edge_time;
        n_pressed        = r_pressed;
        n_press_start    = r_press_start;
        n_swallow        = r_swallow;
        n_awaiting       = r_awaiting;
        n_second_press   = r_second_press;
        n_first_release  = r_first_release;
        n_talk           = r_talk;
        n_action         = bgr_pkg::ACT_NONE;
        unique case (bgr_pkg::t_op'(r_in_op))
            bgr_pkg::OP_PRESS: begin
                if (!edge_dropped) begin
                    n_edge_seen      = 1'b1;
                    n_last_edge_time = r_in_now;
                    if (!r_pressed) begin
                        n_pressed     = 1'b1;
                        n_press_start = r_in_now;
                        if (!r_in_scr) begin
                            n_swallow      = 1'b1;
                            n_awaiting     = 1'b0;
                            n_second_press = 1'b0;
                            n_action       = bgr_pkg::ACT_WAKE;
                        end else if (!r_in_ok) begin
                            n_swallow = 1'b1;
                        end else begin
                            n_second_press = r_awaiting && in_dbl_window;
                            n_action       = bgr_pkg::ACT_PRE_BEG;
                        end
                    end
                end
            end
            bgr_pkg::OP_RELEASE: begin
                if (!edge_dropped) begin
                    n_edge_seen      = 1'b1;
                    n_last_edge_time = r_in_now;
                    if (r_pressed) begin
                        n_pressed = 1'b0;
                        if (r_swallow) begin
                            n_swallow      = 1'b0;
                            n_talk         = 1'b0;
                            n_second_press = 1'b0;
                        end else if (r_talk) begin
                            n_talk         = 1'b0;
                            n_awaiting     = 1'b0;
                            n_second_press = 1'b0;
                            n_action       = bgr_pkg::ACT_PTT_END;
                        end else if (!r_in_ok) begin
                            n_awaiting     = 1'b0;
                            n_second_press = 1'b0;
                            n_action       = bgr_pkg::ACT_PRE_DISC;
                        end else if (r_second_press) begin
                            n_awaiting     = 1'b0;
                            n_second_press = 1'b0;
                            n_action       = bgr_pkg::ACT_ESCAPE;
                        end else begin
                            n_awaiting      = 1'b1;
                            n_first_release = r_in_now;
                            n_action        = bgr_pkg::ACT_PRE_DISC;
                        end
                    end
                end
            end
            bgr_pkg::OP_TICK: begin
                if (r_pressed && !r_swallow && !r_talk && r_in_ok && hold_reached) begin
                    n_talk         = 1'b1;
                    n_awaiting     = 1'b0;
                    n_second_press = 1'b0;
                    n_action       = bgr_pkg::ACT_PTT_BEG;
                end else if (!r_pressed && r_awaiting && dbl_expired) begin
                    n_awaiting = 1'b0;
                    n_action   = r_in_ok ? bgr_pkg::ACT_ENTER : bgr_pkg::ACT_NONE;
                end
            end
            default: begin
                n_action = bgr_pkg::ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= bgr_pkg::DebounceReset;
            r_dbl_window <= bgr_pkg::DoubleClickReset;
            r_hold       <= bgr_pkg::HoldReset;
        end else if (i_cfg_we) begin
            unique case (bgr_pkg::t_cfg_idx'(i_cfg_idx))
                bgr_pkg::CFG_DEBOUNCE:     r_debounce   <= i_cfg_data;
                bgr_pkg::CFG_DOUBLE_CLICK: r_dbl_window <= i_cfg_data;
                bgr_pkg::CFG_HOLD:         r_hold       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_op  <= i_evt.operation;
            r_in_now <= i_evt.now_ms;
            r_in_scr <= i_evt.display_on;
            r_in_ok  <= i_evt.view_open && i_evt.sess_picked &&
                        !i_evt.input_locked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_act.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_action <= n_action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_seen      <= 1'b0;
            r_last_edge_time <= '0;
            r_pressed        <= 1'b0;
            r_press_start    <= '0;
            r_swallow        <= 1'b0;
            r_awaiting       <= 1'b0;
            r_second_press   <= 1'b0;
            r_first_release  <= '0;
            r_talk           <= 1'b0;
        end else if (advance) begin
            r_edge_seen      <= n_edge_seen;
            r_last_edge_time <= n_last_edge_time;
            r_pressed        <= n_pressed;
            r_press_start    <= n_press_start;
            r_swallow        <= n_swallow;
            r_awaiting       <= n_awaiting;
            r_second_press   <= n_second_press;
            r_first_release  <= n_first_release;
            r_talk           <= n_talk;
        end
    end

    `BGR_ASSERT_NOW(a_talk_needs_press, i_clk, i_rst_n, r_talk, r_pressed && !r_swallow)
    `BGR_ASSERT_NOW(a_second_press_pending, i_clk, i_rst_n, r_second_press, r_awaiting && r_pressed)
    `BGR_ASSERT_NOW(a_swallow_needs_press, i_clk, i_rst_n, r_swallow, r_pressed)
    `BGR_ASSERT_NEXT(a_advance_fills_result, i_clk, i_rst_n, advance, r_out_valid)
    `BGR_ASSERT_NEXT(a_input_held, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid)

endmodule

// ===== tb/tb_button_gesture_recognizer_unit.sv =====
// Self-checking testbench for the button gesture recognizer: predicts and checks every action.
module tb_button_gesture_recognizer_unit;

    localparam logic [bgr_pkg::OpW-1:0]     OpUnused   = 2'd3;
    localparam logic [bgr_pkg::CfgIdxW-1:0] CfgUnused  = 2'd3;
    localparam int unsigned                 CycleLimit = 500000;

    typedef struct packed {
        logic [bgr_pkg::OpW-1:0]   op;
        logic [bgr_pkg::TimeW-1:0] now_ms;
        logic                      display_on;
        logic                      view_open;
        logic                      sess_picked;
        logic                      input_locked;
    } t_button_evt;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [bgr_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [bgr_pkg::CfgW-1:0]     i_cfg_data;

    bgr_in_if  evt_if ();
    bgr_out_if act_if ();

    button_gesture_recognizer_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt_if),
        .o_act      (act_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // timing registers and gesture state as the block should hold them
    logic [bgr_pkg::CfgW-1:0]  cfg_debounce;
    logic [bgr_pkg::CfgW-1:0]  cfg_dclick;
    logic [bgr_pkg::CfgW-1:0]  cfg_hold;
    logic                      btn_edge_seen;
    logic [bgr_pkg::TimeW-1:0] btn_last_edge;
    logic                      btn_down;
    logic [bgr_pkg::TimeW-1:0] btn_down_at;
    logic                      btn_swallow;
    logic                      dc_waiting;
    logic                      dc_second;
    logic [bgr_pkg::TimeW-1:0] dc_release_at;
    logic                      talk_on;

    t_button_evt               pend_q[$];
    bgr_pkg::t_action          act_expect_q[$];

    logic                      evt_taken   = 1'b0;
    int unsigned               evt_gap     = 0;
    bit                        evt_steady  = 1'b0;
    int unsigned               act_stall   = 0;
    bit                        act_steady  = 1'b0;
    int unsigned               err_count   = 0;
    int unsigned               cycle_count = 0;
    int unsigned               gen_count   = 0;
    logic [bgr_pkg::TimeW-1:0] gen_now     = '0;
    logic [bgr_pkg::CfgW-1:0]  gen_deb     = bgr_pkg::DebounceReset;
    logic [bgr_pkg::CfgW-1:0]  gen_dc      = bgr_pkg::DoubleClickReset;
    logic [bgr_pkg::CfgW-1:0]  gen_hold    = bgr_pkg::HoldReset;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    task automatic flag_error(string msg);
        $display("mismatch @%0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic clear_gesture_state();
        cfg_debounce  = bgr_pkg::DebounceReset;
        cfg_dclick    = bgr_pkg::DoubleClickReset;
        cfg_hold      = bgr_pkg::HoldReset;
        btn_edge_seen = 1'b0;
        btn_last_edge = '0;
        btn_down      = 1'b0;
        btn_down_at   = '0;
        btn_swallow   = 1'b0;
        dc_waiting    = 1'b0;
        dc_second     = 1'b0;
        dc_release_at = '0;
        talk_on       = 1'b0;
    endtask

    function automatic bit edge_bounced(logic [bgr_pkg::TimeW-1:0] t);
        logic [bgr_pkg::TimeW-1:0] dt;
        dt = t - btn_last_edge;
        if (btn_edge_seen && dt < {16'd0, cfg_debounce}) return 1'b1;
        btn_edge_seen = 1'b1;
        btn_last_edge = t;
        return 1'b0;
    endfunction

    function automatic bgr_pkg::t_action predict_action(t_button_evt e);
        logic                      ok;
        logic [bgr_pkg::TimeW-1:0] t;
        ok = e.view_open && e.sess_picked && !e.input_locked;
        t  = e.now_ms;
        case (e.op)
            bgr_pkg::OP_PRESS: begin
                if (edge_bounced(t) || btn_down) return bgr_pkg::ACT_NONE;
                btn_down    = 1'b1;
                btn_down_at = t;
                if (!e.display_on) begin
                    btn_swallow = 1'b1;
                    dc_waiting  = 1'b0;
                    dc_second   = 1'b0;
                    return bgr_pkg::ACT_WAKE;
                end
                if (!ok) begin
                    btn_swallow = 1'b1;
                    return bgr_pkg::ACT_NONE;
                end
                dc_second = dc_waiting && ((t - dc_release_at) <= {16'd0, cfg_dclick});
                return bgr_pkg::ACT_PRE_BEG;
            end
            bgr_pkg::OP_RELEASE: begin
                if (edge_bounced(t) || !btn_down) return bgr_pkg::ACT_NONE;
                btn_down = 1'b0;
                if (btn_swallow) begin
                    btn_swallow = 1'b0;
                    talk_on     = 1'b0;
                    dc_second   = 1'b0;
                    return bgr_pkg::ACT_NONE;
                end
                if (talk_on) begin
                    talk_on    = 1'b0;
                    dc_waiting = 1'b0;
                    dc_second  = 1'b0;
                    return bgr_pkg::ACT_PTT_END;
                end
                if (!ok) begin
                    dc_waiting = 1'b0;
                    dc_second  = 1'b0;
                    return bgr_pkg::ACT_PRE_DISC;
                end
                if (dc_second) begin
                    dc_waiting = 1'b0;
                    dc_second  = 1'b0;
                    return bgr_pkg::ACT_ESCAPE;
                end
                dc_waiting    = 1'b1;
                dc_release_at = t;
                return bgr_pkg::ACT_PRE_DISC;
            end
            bgr_pkg::OP_TICK: begin
                if (btn_down && !btn_swallow && !talk_on && ok &&
                    (t - btn_down_at) >= {16'd0, cfg_hold}) begin
                    talk_on    = 1'b1;
                    dc_waiting = 1'b0;
                    dc_second  = 1'b0;
                    return bgr_pkg::ACT_PTT_BEG;
                end
                if (!btn_down && dc_waiting && (t - dc_release_at) >= {16'd0, cfg_dclick}) begin
                    dc_waiting = 1'b0;
                    return ok ? bgr_pkg::ACT_ENTER : bgr_pkg::ACT_NONE;
                end
                return bgr_pkg::ACT_NONE;
            end
            default: return bgr_pkg::ACT_NONE;
        endcase
    endfunction

    // sample transfers, predict, check
    always @(posedge i_clk) begin
        t_button_evt      e;
        bgr_pkg::t_action want;
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end else if (i_rst_n !== 1'b1) begin
            clear_gesture_state();
            evt_taken <= 1'b0;
        end else begin
            evt_taken <= evt_if.valid && evt_if.ready;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bgr_pkg::CFG_DEBOUNCE:     cfg_debounce = i_cfg_data;
                    bgr_pkg::CFG_DOUBLE_CLICK: cfg_dclick   = i_cfg_data;
                    bgr_pkg::CFG_HOLD:         cfg_hold     = i_cfg_data;
                    default: ;
                endcase
            end
            if (evt_if.valid && evt_if.ready) begin
                e.op           = evt_if.operation;
                e.now_ms       = evt_if.now_ms;
                e.display_on   = evt_if.display_on;
                e.view_open    = evt_if.view_open;
                e.sess_picked  = evt_if.sess_picked;
                e.input_locked = evt_if.input_locked;
                act_expect_q.push_back(predict_action(e));
            end
            if (act_if.valid && act_if.ready) begin
                if (act_expect_q.size() == 0) begin
                    flag_error($sformatf("unexpected action %0d", act_if.action));
                end else begin
                    want = act_expect_q.pop_front();
                    if (act_if.action !== want)
                        flag_error($sformatf("action %0d, expected %s",
                                             act_if.action, want.name()));
                end
            end
        end
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge i_clk) begin
        t_button_evt e;
        logic        hold_valid;
        hold_valid = evt_if.valid && !evt_taken;
        if (!hold_valid && i_rst_n === 1'b1) begin
            if (evt_gap != 0) begin
                evt_gap--;
            end else if (pend_q.size() != 0) begin
                e = pend_q.pop_front();
                evt_if.operation    <= e.op;
                evt_if.now_ms       <= e.now_ms;
                evt_if.display_on   <= e.display_on;
                evt_if.view_open    <= e.view_open;
                evt_if.sess_picked  <= e.sess_picked;
                evt_if.input_locked <= e.input_locked;
                hold_valid = 1'b1;
                if ($urandom_range(0, 99) < 3) evt_steady = !evt_steady;
                evt_gap = evt_steady ? 0 : idle_len();
            end
        end
        evt_if.valid <= hold_valid;
    end

    always @(negedge i_clk) begin
        if (act_stall != 0) begin
            act_stall--;
            act_if.ready <= 1'b0;
        end else begin
            act_if.ready <= 1'b1;
            if ($urandom_range(0, 99) < 3) act_steady = !act_steady;
            if (!act_steady && $urandom_range(0, 99) < 35) act_stall = idle_len();
        end
    end

    task automatic queue_at(logic [bgr_pkg::OpW-1:0] op, logic [bgr_pkg::TimeW-1:0] t,
                            logic scr, logic det, logic sel, logic lck);
        t_button_evt e;
        e.op           = op;
        e.now_ms       = t;
        e.display_on   = scr;
        e.view_open    = det;
        e.sess_picked  = sel;
        e.input_locked = lck;
        gen_now = t;
        pend_q.push_back(e);
        gen_count++;
    endtask

    // advance time and queue an event, mostly with a context that allows input
    task automatic queue_step(logic [bgr_pkg::OpW-1:0] op, logic [bgr_pkg::TimeW-1:0] dt);
        if ($urandom_range(0, 99) < 85)
            queue_at(op, gen_now + dt, 1'b1, 1'b1, 1'b1, 1'b0);
        else
            queue_at(op, gen_now + dt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [bgr_pkg::TimeW-1:0] span(logic [bgr_pkg::CfgW-1:0] thr);
        logic [bgr_pkg::TimeW-1:0] base;
        base = {16'd0, thr};
        case ($urandom_range(0, 4))
            0:       return (base == 0) ? base : base - 1;
            1:       return base;
            2:       return base + 1;
            3:       return $urandom_range(0, base);
            default: return base + $urandom_range(1, base + 8);
        endcase
    endfunction

    function automatic logic [bgr_pkg::TimeW-1:0] edge_dt();
        if ($urandom_range(0, 99) < 80)
            return {16'd0, gen_deb} + $urandom_range(0, gen_deb / 2 + 5);
        return span(gen_deb);
    endfunction

    task automatic add_gestures(int unsigned n);
        int unsigned goal;
        int unsigned kind;
        int unsigned k;
        goal = gen_count + n;
        gen_now = $urandom();
        while (gen_count < goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                queue_step(bgr_pkg::OP_PRESS, edge_dt());
                repeat ($urandom_range(0, 2)) queue_step(bgr_pkg::OP_TICK, span(gen_hold) / 4);
                queue_step(bgr_pkg::OP_RELEASE, edge_dt());
                repeat ($urandom_range(1, 3)) queue_step(bgr_pkg::OP_TICK, span(gen_dc) / 2);
            end else if (kind < 55) begin
                queue_step(bgr_pkg::OP_PRESS, edge_dt());
                queue_step(bgr_pkg::OP_RELEASE, edge_dt());
                queue_step(bgr_pkg::OP_PRESS, $urandom_range(0, 1) ? span(gen_dc) : edge_dt());
                queue_step(bgr_pkg::OP_RELEASE, edge_dt());
                queue_step(bgr_pkg::OP_TICK, span(gen_dc));
            end else if (kind < 75) begin
                queue_step(bgr_pkg::OP_PRESS, edge_dt());
                k = $urandom_range(1, 4);
                repeat (k) queue_step(bgr_pkg::OP_TICK, span(gen_hold) / 2);
                queue_step(bgr_pkg::OP_TICK, span(gen_hold));
                queue_step(bgr_pkg::OP_RELEASE, edge_dt());
            end else if (kind < 85) begin
                repeat ($urandom_range(2, 5))
                    queue_step($urandom_range(0, 1) ? bgr_pkg::OP_PRESS : bgr_pkg::OP_RELEASE,
                               span(gen_deb));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1))
                        queue_at(bgr_pkg::OpW'($urandom_range(0, 3)), $urandom(),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    else
                        queue_at(bgr_pkg::OpW'($urandom_range(0, 3)),
                                 gen_now + $urandom_range(0, 64),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    task automatic write_reg(logic [bgr_pkg::CfgIdxW-1:0] idx, logic [bgr_pkg::CfgW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_timing(logic [bgr_pkg::CfgW-1:0] deb, logic [bgr_pkg::CfgW-1:0] dc,
                              logic [bgr_pkg::CfgW-1:0] hold);
        write_reg(bgr_pkg::CFG_DEBOUNCE, deb);
        write_reg(bgr_pkg::CFG_DOUBLE_CLICK, dc);
        write_reg(bgr_pkg::CFG_HOLD, hold);
        gen_deb  = deb;
        gen_dc   = dc;
        gen_hold = hold;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pend_q.size() != 0 || evt_if.valid || act_expect_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = bgr_pkg::CFG_DEBOUNCE;
        i_cfg_data          = '0;
        evt_if.valid        = 1'b0;
        evt_if.operation    = bgr_pkg::OP_TICK;
        evt_if.now_ms       = '0;
        evt_if.display_on   = 1'b0;
        evt_if.view_open    = 1'b0;
        evt_if.sess_picked  = 1'b0;
        evt_if.input_locked = 1'b0;
        act_if.ready        = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_at(OpUnused,           32'd1000, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_PRESS,   32'd1000, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_RELEASE, 32'd1010, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_RELEASE, 32'd1100, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_RELEASE, 32'd1200, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_PRESS,   32'd1300, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_at(bgr_pkg::OP_PRESS,   32'd1400, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_RELEASE, 32'd1500, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_PRESS,   32'd1600, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_RELEASE, 32'd1700, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_PRESS,   32'd1800, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_RELEASE, 32'd1900, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_PRESS,   32'd2000, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_TICK,    32'd2500, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_RELEASE, 32'd2600, 1'b1, 1'b0, 1'b0, 1'b1);
        queue_at(bgr_pkg::OP_PRESS,   32'd2700, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_RELEASE, 32'd2800, 1'b1, 1'b0, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_PRESS,   32'd2900, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_RELEASE, 32'd3000, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_TICK,    32'd3349, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_TICK,    32'd3350, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_PRESS,   32'd3400, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_RELEASE, 32'd3500, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_TICK,    32'd3900, 1'b1, 1'b1, 1'b0, 1'b0);
        queue_at(bgr_pkg::OP_PRESS,   32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_RELEASE, 32'h0000_0020, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_at(bgr_pkg::OP_PRESS,   32'h0000_0010, 1'b1, 1'b1, 1'b1, 1'b0);
        drain();

        set_timing(16'd0, 16'd0, 16'd0);
        write_reg(CfgUnused, bgr_pkg::CfgW'($urandom()));
        add_gestures(200);
        drain();

        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_gestures(200);
        drain();

        repeat (3) begin
            set_timing(bgr_pkg::CfgW'($urandom_range(1, 60)),
                       bgr_pkg::CfgW'($urandom_range(20, 400)),
                       bgr_pkg::CfgW'($urandom_range(20, 600)));
            add_gestures(300);
            drain();
        end

        if (err_count == 0 && act_expect_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
